### rtl/core/hgl_pkg.sv
// shared types and constants for the hex grid land/water edge counter
package hgl_pkg;

    localparam int ROW_WIDTH_BITS = 7;
    localparam int OUT_BITS       = 16;
    localparam int PADDR_BITS     = 3;
    localparam int PDATA_BITS     = 32;

    localparam logic [PADDR_BITS-1:0]     ROW_WIDTH_ADDR  = 3'd0;
    localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 7'd64;

    typedef struct packed {
        logic       last;
        logic [1:0] add;
    } t_cell_ev;

endpackage

### rtl/core/hgl_cfg.sv
// apb register block holding the row width
module hgl_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hgl_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [hgl_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [hgl_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                 pready,
    output logic [hgl_pkg::ROW_WIDTH_BITS-1:0]   o_row_width
);

    logic [hgl_pkg::ROW_WIDTH_BITS-1:0] r_row_width;
    logic [hgl_pkg::ROW_WIDTH_BITS-1:0] n_row_width;
    logic                               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_row_width = r_row_width;
        if (wr_en && (paddr == hgl_pkg::ROW_WIDTH_ADDR)) begin
            n_row_width = pwdata[hgl_pkg::ROW_WIDTH_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= hgl_pkg::ROW_WIDTH_RESET;
        end else begin
            r_row_width <= n_row_width;
        end
    end

    always_comb begin
        unique case (paddr)
            hgl_pkg::ROW_WIDTH_ADDR: begin
                prdata = {{(hgl_pkg::PDATA_BITS-hgl_pkg::ROW_WIDTH_BITS){1'b0}}, r_row_width};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_row_width = r_row_width;

endmodule

### rtl/core/hgl_cell_proc.sv
// column tracking, previous-row buffer and neighbor compare for one cell
module hgl_cell_proc #(
    parameter int MAX_COLS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic                               i_is_land,
    input  logic                               i_last_cell,
    input  logic [hgl_pkg::ROW_WIDTH_BITS-1:0] i_row_width,
    output hgl_pkg::t_cell_ev                  o_ev
);

    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int WBR = $clog2(MAX_COLS + 2);
    localparam int WB  = (WBR > hgl_pkg::ROW_WIDTH_BITS + 1) ? WBR
                                                              : hgl_pkg::ROW_WIDTH_BITS + 1;

    logic          mem [MAX_COLS];
    logic          r_rd_a;
    logic          r_rd_b;
    logic [CW-1:0] r_col;
    logic          r_odd;
    logic          r_first;
    logic          r_left;
    logic          r_ul;
    logic          r_above;
    logic          r_use_a;

    logic [CW-1:0] n_col;
    logic          n_odd;
    logic          n_first;

    logic [WB-1:0] rw_ext;
    logic [WB-1:0] w_eff;
    logic [WB-1:0] col_ext;
    logic [WB-1:0] col_p1;
    logic [WB-1:0] col_p2;
    logic [WB-1:0] rd_b_sel;
    logic [CW-1:0] rd_b_addr;
    logic          above;
    logic          wrap;
    logic          row_end;
    logic          t_left;
    logic          t_up;
    logic          t_up_r;
    logic          t_up_l;

    assign rw_ext  = WB'(i_row_width);
    assign col_ext = WB'(r_col);
    assign col_p1  = col_ext + WB'(1);
    assign col_p2  = col_ext + WB'(2);

    always_comb begin
        if (rw_ext == '0) begin
            w_eff = WB'(1);
        end else if (rw_ext > WB'(MAX_COLS)) begin
            w_eff = WB'(MAX_COLS);
        end else begin
            w_eff = rw_ext;
        end
    end

    assign above   = r_use_a ? r_rd_a : r_above;
    assign wrap    = (col_p1 >= w_eff);
    assign row_end = wrap || i_last_cell;

    assign t_left = (r_col != '0) && (r_left != i_is_land);
    assign t_up   = !r_first && (above != i_is_land);
    assign t_up_r = !r_first && r_odd && (col_p1 < w_eff) && (r_rd_b != i_is_land);
    assign t_up_l = !r_first && !r_odd && (r_col != '0) && (r_ul != i_is_land);

    assign o_ev.last = i_last_cell;
    assign o_ev.add  = 2'(t_left) + 2'(t_up) + 2'(t_up_r) + 2'(t_up_l);

    assign rd_b_sel  = row_end ? WB'(1) : col_p2;
    assign rd_b_addr = (rd_b_sel < WB'(MAX_COLS)) ? CW'(rd_b_sel) : '0;

    always_comb begin
        n_col   = r_col;
        n_odd   = r_odd;
        n_first = r_first;
        if (i_last_cell) begin
            n_col   = '0;
            n_odd   = 1'b0;
            n_first = 1'b1;
        end else if (wrap) begin
            n_col   = '0;
            n_odd   = !r_odd;
            n_first = 1'b0;
        end else begin
            n_col   = CW'(col_p1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            mem[r_col] <= i_is_land;
            r_rd_a     <= (r_col == '0) ? i_is_land : mem[0];
            r_rd_b     <= (rd_b_addr == r_col) ? i_is_land : mem[rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_above <= r_rd_b;
            r_ul    <= row_end ? 1'b0 : above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_odd   <= 1'b0;
            r_first <= 1'b1;
            r_left  <= 1'b0;
            r_use_a <= 1'b1;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_odd   <= n_odd;
            r_first <= n_first;
            r_left  <= row_end ? 1'b0 : i_is_land;
            r_use_a <= row_end;
        end
    end

endmodule

### rtl/core/hgl_accum.sv
// saturating edge counter and result word register
module hgl_accum #(
    parameter int COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  hgl_pkg::t_cell_ev            i_ev,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [hgl_pkg::OUT_BITS-1:0] o_beach_length
);

    logic [COUNT_BITS-1:0]                  r_count;
    logic                                   r_out_valid;
    logic [hgl_pkg::OUT_BITS-1:0]           r_out_data;
    logic [COUNT_BITS:0]                    sum;
    logic [COUNT_BITS-1:0]                  n_sat;
    logic [COUNT_BITS+hgl_pkg::OUT_BITS-1:0] sat_ext;

    assign sum     = {1'b0, r_count} + (COUNT_BITS+1)'(i_ev.add);
    assign n_sat   = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    assign sat_ext = {{hgl_pkg::OUT_BITS{1'b0}}, n_sat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_count <= i_ev.last ? '0 : n_sat;
            end
            if (i_accept && i_ev.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_ev.last) begin
            r_out_data <= sat_ext[hgl_pkg::OUT_BITS-1:0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_beach_length = r_out_data;

endmodule

### rtl/core/hex_grid_land_water_edge_count.sv
// top level: hex grid land/water edge counter with apb width register
// the total is registered and appears on o_valid in the cycle after the last cell word is accepted
// throughput: one cell word per cycle while o_stall is low
// the input stalls only while a finished total waits and the output is stalled
// reset (i_rst_n low, synchronous): new image at row 0, count zero, row width 64
// the previous-row buffer is not cleared; it is refilled by the first row of each image
module hex_grid_land_water_edge_count #(
    parameter int MAX_COLS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_is_land,
    input  logic                                i_last_cell,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [hgl_pkg::OUT_BITS-1:0]        o_beach_length,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hgl_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [hgl_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [hgl_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                pready
);

    logic                               accept;
    logic [hgl_pkg::ROW_WIDTH_BITS-1:0] row_width;
    hgl_pkg::t_cell_ev                  cell_ev;

    assign o_stall = o_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    hgl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_row_width (row_width)
    );

    hgl_cell_proc #(
        .MAX_COLS (MAX_COLS)
    ) u_cell_proc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_is_land   (i_is_land),
        .i_last_cell (i_last_cell),
        .i_row_width (row_width),
        .o_ev        (cell_ev)
    );

    hgl_accum #(
        .COUNT_BITS (COUNT_BITS)
    ) u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_ev           (cell_ev),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_beach_length (o_beach_length)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending total");

    a_last_gives_total : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_cell) |=> o_valid)
        else $error("no total after last cell");

    a_no_spurious_total : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && i_valid && !o_stall && !i_last_cell) |=> !o_valid)
        else $error("total without last cell");
`endif

endmodule

### test/tb_hex_grid_land_water_edge_count.sv
// testbench for the hex grid land/water edge counter: cell stream driver, total checker, apb setup
`timescale 1ns / 1ps

module tb_hex_grid_land_water_edge_count;

    localparam int GRID_COLS   = 64;
    localparam int TOTAL_MAX   = (1 << 16) - 1;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_CELLS = 50;
    localparam int LONG_CELLS  = 128;

    typedef struct packed {
        logic land;
        logic last;
    } t_cell_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_is_land = 1'b0;
    logic i_last_cell = 1'b0;
    logic i_stall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [hgl_pkg::PADDR_BITS-1:0] paddr = hgl_pkg::ROW_WIDTH_ADDR;
    logic [hgl_pkg::PDATA_BITS-1:0] pwdata = '0;
    logic o_stall;
    logic o_valid;
    logic [hgl_pkg::OUT_BITS-1:0] o_beach_length;
    logic [hgl_pkg::PDATA_BITS-1:0] prdata;
    logic pready;

    hex_grid_land_water_edge_count dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_is_land      (i_is_land),
        .i_last_cell    (i_last_cell),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_beach_length (o_beach_length),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    t_cell_word        cells_pending[$];
    logic [15:0]       expected_totals[$];
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                errors = 0;
    int                cells_taken = 0;
    int                totals_seen = 0;
    int                width_writes = 0;
    logic              cell_taken = 1'b0;

    // edge count shadow state
    logic              shadow_row[GRID_COLS];
    logic [6:0]        width_reg = hgl_pkg::ROW_WIDTH_RESET;
    int                cur_col;
    logic              odd_row;
    logic              first_row;
    logic              left_land;
    logic              upper_left;
    int                edge_total;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int eff_cols(input logic [6:0] v);
        if (v == 0) return 1;
        if (v > GRID_COLS) return GRID_COLS;
        return int'(v);
    endfunction

    function automatic void start_image();
        cur_col = 0;
        odd_row = 1'b0;
        first_row = 1'b1;
        left_land = 1'b0;
        upper_left = 1'b0;
        edge_total = 0;
    endfunction

    function automatic void count_edges(input logic land, input logic last);
        int   w;
        int   col;
        int   add;
        logic above;
        w = eff_cols(width_reg);
        col = cur_col;
        add = 0;
        above = shadow_row[col];
        if (col > 0 && left_land != land) add++;
        if (!first_row) begin
            if (above != land) add++;
            if (odd_row) begin
                if (col + 1 < w && shadow_row[col + 1] != land) add++;
            end else begin
                if (col > 0 && upper_left != land) add++;
            end
        end
        upper_left = above;
        shadow_row[col] = land;
        edge_total += add;
        if (edge_total > TOTAL_MAX) edge_total = TOTAL_MAX;
        left_land = land;
        if (last) begin
            expected_totals.push_back(edge_total[15:0]);
            start_image();
        end else if (col + 1 >= w) begin
            cur_col = 0;
            odd_row = ~odd_row;
            first_row = 1'b0;
            left_land = 1'b0;
            upper_left = 1'b0;
        end else begin
            cur_col = col + 1;
        end
    endfunction

    // accepted cell words feed the shadow model
    always @(posedge i_clk) begin
        cell_taken = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            cell_taken = 1'b1;
            cells_taken++;
            count_edges(i_is_land, i_last_cell);
        end
    end

    // cell word driver
    always @(negedge i_clk) begin
        t_cell_word nxt;
        logic       nv;
        nv = i_valid;
        if (cell_taken) nv = 1'b0;
        if (i_rst_n && !nv && cells_pending.size() > 0 &&
            !(send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)) begin
            nxt = cells_pending.pop_front();
            i_is_land <= nxt.land;
            i_last_cell <= nxt.last;
            nv = 1'b1;
        end
        i_valid <= nv;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // total monitor
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            totals_seen++;
            if (expected_totals.size() == 0) begin
                report_mismatch($sformatf("unexpected total %0d", o_beach_length));
            end else begin
                want = expected_totals.pop_front();
                if (o_beach_length !== want)
                    report_mismatch($sformatf("beach_length %0d, want %0d",
                                              o_beach_length, want));
            end
        end
    end

    task automatic push_cell(input logic land, input logic last);
        t_cell_word c;
        c.land = land;
        c.last = last;
        cells_pending.push_back(c);
    endtask

    task automatic wait_quiet();
        while (cells_pending.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [6:0] val);
        logic [hgl_pkg::PDATA_BITS-1:0] data;
        data = $urandom;
        data[6:0] = val;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= hgl_pkg::ROW_WIDTH_ADDR;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        width_reg = val;
        width_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[6:0] !== val)
            report_mismatch($sformatf("row_width reads %0d, want %0d", prdata[6:0], val));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 45; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 45; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
        endcase
    endtask

    initial begin
        int   ph;
        int   n;
        int   k;
        int   len;
        int   ew;
        int   r;
        logic [6:0] w;
        logic land;
        logic clumpy;

        for (k = 0; k < GRID_COLS; k++) shadow_row[k] = 1'b0;
        start_image();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: single-cell images and one two-cell image at the reset width
        set_idling(0);
        push_cell(1'b1, 1'b1);
        push_cell(1'b0, 1'b1);
        push_cell(1'b1, 1'b0);
        push_cell(1'b0, 1'b1);
        wait_quiet();
        // one-column image
        write_width(7'd1);
        push_cell(1'b1, 1'b0);
        push_cell(1'b0, 1'b0);
        push_cell(1'b1, 1'b0);
        push_cell(1'b1, 1'b1);
        wait_quiet();
        // three columns, image ends mid-row
        write_width(7'd3);
        set_idling(3);
        for (k = 0; k < 8; k++) push_cell(k[0], k == 7);
        wait_quiet();
        // zero width acts as one
        write_width(7'd0);
        push_cell(1'b0, 1'b0);
        push_cell(1'b1, 1'b0);
        push_cell(1'b0, 1'b1);
        wait_quiet();
        // width above the buffer acts as the buffer size
        write_width(7'd127);
        push_cell(1'b1, 1'b0);
        push_cell(1'b1, 1'b0);
        push_cell(1'b0, 1'b1);
        wait_quiet();
        // all land, no edges
        write_width(7'd2);
        for (k = 0; k < 4; k++) push_cell(1'b1, k == 3);
        wait_quiet();

        // two striped full-width rows write every buffer entry
        write_width(7'd64);
        set_idling(0);
        for (k = 0; k < LONG_CELLS; k++) push_cell(k[6], k == LONG_CELLS - 1);
        wait_quiet();

        // random images, some phases leave an image open across the width change
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_quiet();
            r = $urandom_range(9);
            if (r == 0) w = 7'd0;
            else if (r == 1) w = 7'd64;
            else if (r == 2) w = 7'($urandom_range(65, 127));
            else w = 7'($urandom_range(1, 12));
            write_width(w);
            set_idling(ph % 4);
            ew = eff_cols(w);
            n = 0;
            while (n < PHASE_CELLS) begin
                if ($urandom_range(99) < 85) begin
                    len = $urandom_range(1, ew * $urandom_range(1, 4));
                    clumpy = 1'($urandom_range(1));
                    land = 1'($urandom_range(1));
                    for (k = 0; k < len; k++) begin
                        if (!clumpy) land = 1'($urandom_range(1));
                        else if ($urandom_range(7) == 0) land = ~land;
                        push_cell(land, k == len - 1);
                    end
                end else begin
                    len = $urandom_range(1, 6);
                    for (k = 0; k < len; k++)
                        push_cell(1'($urandom_range(1)), $urandom_range(3) == 0);
                end
                n += len;
            end
            if (ph % 2 == 1) begin
                len = $urandom_range(1, 2 * ew);
                for (k = 0; k < len; k++) push_cell(1'($urandom_range(1)), 1'b0);
            end
        end
        wait_quiet();

        while (expected_totals.size() != 0) begin
            report_mismatch($sformatf("total %0d never arrived", expected_totals.pop_front()));
        end
        $display("run covered %0d cell words, %0d image totals, %0d width settings",
                 cells_taken, totals_seen, width_writes);
        $display("widths included zero, one, the buffer size and above; open images crossed width changes");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: the block stopped making progress");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
